// File: rtl/vfg_pkg.sv
// ============================================================================
// vfg_pkg
// Types, constants and the 2^x root table shared by the fade gain block.
// ============================================================================
package vfg_pkg;

    typedef logic signed [15:0] t_sample;
    typedef logic signed [24:0] t_gain_db;
    typedef logic        [21:0] t_lin;
    typedef logic        [12:0] t_frames;
    typedef logic        [15:0] t_fade;
    typedef logic        [28:0] t_step;
    typedef logic         [1:0] t_cfg_idx;
    typedef logic        [24:0] t_cfg_data;

    // Register map of the configuration port
    localparam t_cfg_idx CFG_TARGET_GAIN    = 2'd0;
    localparam t_cfg_idx CFG_MUTE_LEVEL     = 2'd1;
    localparam t_cfg_idx CFG_MUTED          = 2'd2;
    localparam t_cfg_idx CFG_FADE_PER_FRAME = 2'd3;

    localparam t_gain_db RST_TARGET_GAIN    = 25'sd0;
    localparam t_gain_db RST_MUTE_LEVEL     = -25'sd13107200;
    localparam t_fade    RST_FADE_PER_FRAME = 16'd3277;

    // Frame counts above this are clamped
    localparam int MAX_FRAMES = 4096;

    // round(2^32 * log2(10) / 20)
    localparam logic signed [30:0] LOG_COEF = 31'sd713378626;
    localparam t_lin LIN_MAX  = 22'h3FFFFF;
    localparam t_lin LIN_UNITY = 22'd65536;

    typedef struct packed {
        t_gain_db gain_db;
        t_lin     lin;
    } t_gain_state;

    localparam t_gain_state GAIN_STATE_RST = '{gain_db: 25'sd0, lin: LIN_UNITY};

    typedef logic [15:0][30:0] t_root_tab;

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Entry i is 2^(2^-(i+1)) in Q30, built by repeated floor square roots
    function automatic t_root_tab calc_roots();
        t_root_tab       tab;
        longint unsigned prev;
        prev   = isqrt64(64'h2000_0000_0000_0000);
        tab[0] = prev[30:0];
        for (int i = 1; i < 16; i++) begin
            prev   = isqrt64(prev << 30);
            tab[i] = prev[30:0];
        end
        return tab;
    endfunction

    localparam t_root_tab POW_ROOT = calc_roots();

endpackage

// File: rtl/vfg_in_if.sv
// ============================================================================
// vfg_in_if
// Sample request channel into the fade gain block.
// ============================================================================
interface vfg_in_if import vfg_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    first_in_buffer;
    t_frames buf_frames;

    modport source (output valid, output sample, output first_in_buffer,
                    output buf_frames, input ready);
    modport sink   (input valid, input sample, input first_in_buffer,
                    input buf_frames, output ready);
endinterface

// File: rtl/vfg_out_if.sv
// ============================================================================
// vfg_out_if
// Scaled sample request channel out of the fade gain block.
// ============================================================================
interface vfg_out_if import vfg_pkg::*; ();
    logic     valid;
    logic     ready;
    t_sample  scaled_sample;
    t_gain_db gain_now;

    modport source (output valid, output scaled_sample, output gain_now, input ready);
    modport sink   (input valid, input scaled_sample, input gain_now, output ready);
endinterface

// File: rtl/volume_fade_gain.sv
// ============================================================================
// volume_fade_gain
// Fading volume control: dB gain ramp, dB to linear, scale and saturate.
// ============================================================================
// Usage:
//   i_in carries signed 16-bit samples; the first sample of each buffer sets
//   first_in_buffer and carries the buffer's frame count. o_out returns one
//   scaled sample per request together with the dB gain applied to it.
//   The configuration port writes the target gain, mute level, mute flag and
//   fade rate; write only while no request is in flight.
// Processing:
//   A plain sample: state memory read at accept, then multiply/round/
//   saturate into the output register; the next request is taken only
//   after that. A first-in-buffer sample: fade update, then the dB to
//   linear converter, whose 16 serial 2^x steps share one multiplier; the
//   new gain is written back to the state memory, then the sample is scaled
//   into the output register before the next request is taken.
// Reset:
//   Gain returns to 0 dB (unity factor) through the state memory valid bit;
//   registers return to their defaults.
// Stall:
//   A result waits in the output register while o_out.ready is low; the next
//   request is still accepted and processed up to the scale step.
// ============================================================================
module volume_fade_gain import vfg_pkg::*; #(
    parameter int GAIN_TABLE_FRAC_BITS = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_cfg_idx  i_cfg_idx,
    input  t_cfg_data i_cfg_wdata,
    vfg_in_if.sink    i_in,
    vfg_out_if.source o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CONV  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;

    logic [2:0]  r_state, n_state;

    t_gain_db    r_cfg_desired;
    t_gain_db    r_cfg_mute;
    logic        r_cfg_muted;
    t_fade       r_cfg_fade;

    t_sample     r_sample;
    logic        r_first;
    t_step       r_step, n_step;
    t_gain_db    r_gain, n_gain;
    t_lin        r_lin;

    t_gain_state r_mem [1];
    logic        r_mem_vld;
    t_gain_state r_rd_data;

    logic        r_out_vld;
    t_sample     r_out_sample, n_out_sample;
    t_gain_db    r_out_gain;

    logic        accept;
    logic        out_free;
    logic        do_scale;
    logic        cv_start;
    logic        cv_done;
    t_lin        cv_lin;
    logic        mem_we;

    t_frames     fc_clamp;
    t_gain_db    target;
    logic signed [30:0] cur_x, tgt_x, step_x;
    t_lin        sc_lin;
    t_gain_db    sc_gain;
    logic signed [38:0] sc_prod;
    logic        [37:0] sc_mag;
    logic        [21:0] sc_rnd;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_vld || o_out.ready;
    assign do_scale   = out_free && ((r_state == S_READ && !r_first) || r_state == S_SCALE);
    assign cv_start   = (r_state == S_CONV);
    assign mem_we     = (r_state == S_WAIT) && cv_done;

    // Fade step, registered at accept
    always_comb begin
        fc_clamp = i_in.buf_frames;
        if ({4'b0, i_in.buf_frames} > 17'(MAX_FRAMES)) begin
            fc_clamp = 13'(MAX_FRAMES);
        end
        n_step = 29'(r_cfg_fade) * 29'(fc_clamp);
    end

    // Move current gain toward target, landing on it within one step
    always_comb begin
        target = r_cfg_muted ? r_cfg_mute : r_cfg_desired;
        cur_x  = 31'(r_rd_data.gain_db);
        tgt_x  = 31'(target);
        step_x = $signed({2'b0, r_step});
        priority if (cur_x < tgt_x - step_x) begin
            n_gain = 25'(cur_x + step_x);
        end else if (cur_x > tgt_x + step_x) begin
            n_gain = 25'(cur_x - step_x);
        end else begin
            n_gain = target;
        end
    end

    // Scale: multiply, round half away from zero, saturate
    always_comb begin
        sc_lin  = (r_state == S_READ) ? r_rd_data.lin : r_lin;
        sc_gain = (r_state == S_READ) ? r_rd_data.gain_db : r_gain;
        sc_prod = 39'(r_sample) * 39'($signed({1'b0, sc_lin}));
        sc_mag  = sc_prod[38] ? 38'(-sc_prod) : sc_prod[37:0];
        sc_rnd  = 22'((sc_mag + 38'd32768) >> 16);
        if (sc_prod[38]) begin
            n_out_sample = (sc_rnd > 22'd32768) ? 16'sh8000 : 16'(-sc_rnd);
        end else begin
            n_out_sample = (sc_rnd > 22'd32767) ? 16'sh7FFF : 16'(sc_rnd);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ: begin
                if (r_first) begin
                    n_state = S_CONV;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CONV:  n_state = S_WAIT;
            S_WAIT:  if (cv_done) n_state = S_SCALE;
            S_SCALE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cfg_desired <= RST_TARGET_GAIN;
            r_cfg_mute    <= RST_MUTE_LEVEL;
            r_cfg_muted   <= 1'b0;
            r_cfg_fade    <= RST_FADE_PER_FRAME;
            r_mem_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TARGET_GAIN:    r_cfg_desired <= i_cfg_wdata;
                    CFG_MUTE_LEVEL:     r_cfg_mute    <= i_cfg_wdata;
                    CFG_MUTED:          r_cfg_muted   <= i_cfg_wdata[0];
                    CFG_FADE_PER_FRAME: r_cfg_fade    <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (mem_we) begin
                r_mem_vld <= 1'b1;
            end
            if (do_scale) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Gain state memory: one entry, read at accept, written after conversion
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[0] <= '{gain_db: r_gain, lin: cv_lin};
        end
        if (accept) begin
            r_rd_data <= r_mem_vld ? r_mem[0] : GAIN_STATE_RST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_in.sample;
            r_first  <= i_in.first_in_buffer;
            r_step   <= n_step;
        end
        if (r_state == S_READ && r_first) begin
            r_gain <= n_gain;
        end
        if (mem_we) begin
            r_lin <= cv_lin;
        end
        if (do_scale) begin
            r_out_sample <= n_out_sample;
            r_out_gain   <= sc_gain;
        end
    end

    vfg_db2lin #(
        .GAIN_TABLE_FRAC_BITS(GAIN_TABLE_FRAC_BITS)
    ) u_db2lin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cv_start),
        .i_gain_db(r_gain),
        .o_done   (cv_done),
        .o_lin    (cv_lin)
    );

    assign o_out.valid         = r_out_vld;
    assign o_out.scaled_sample = r_out_sample;
    assign o_out.gain_now      = r_out_gain;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cv_done |-> r_state == S_WAIT)
        else $error("conversion finished outside wait state");

    a_conv_multicycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cv_start |=> !cv_done)
        else $error("conversion done too early");

    a_scale_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCALE |-> $past(r_state) == S_WAIT || $past(r_state) == S_SCALE)
        else $error("scale state entered without conversion");

    a_vld_set_by_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mem_vld) |-> $past(mem_we))
        else $error("state memory marked valid without write");

endmodule

// File: rtl/vfg_db2lin.sv
// ============================================================================
// vfg_db2lin
// Iterative dB (1/65536 dB) to linear Q16 converter: one exponent multiply,
// sixteen 2^x refinement steps on a shared multiplier, then normalize.
// ============================================================================
module vfg_db2lin import vfg_pkg::*; #(
    parameter int GAIN_TABLE_FRAC_BITS = 6
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_gain_db i_gain_db,
    output logic     o_done,
    output t_lin     o_lin
);

    localparam int FB  = GAIN_TABLE_FRAC_BITS;
    localparam int QS  = 16 - FB;
    localparam int GQW = 10 + FB;
    localparam int EW  = GQW + 31;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_ROOT = 2'd1;
    localparam logic [1:0] C_NORM = 2'd2;

    logic    [1:0]    r_state, n_state;
    logic    [3:0]    r_idx;
    logic signed [EW-1:0] r_e, n_e;
    logic    [31:0]   r_m, n_m;
    logic             r_done;
    t_lin             r_lin, n_lin;

    logic    [25:0]   gu;
    logic    [25:0]   g_round;
    logic signed [GQW-1:0] gq;
    logic    [15:0]   fr;
    logic signed [8:0] oct;
    logic signed [9:0] sh_full;
    logic    [4:0]    sh;
    logic    [62:0]   prod;
    logic    [32:0]   m_rnd;

    // Quantize to the table grid, then exponent in octaves
    always_comb begin
        gu      = {i_gain_db[24], i_gain_db} + 26'(1 << 24);
        g_round = (gu + 26'(1 << (QS - 1))) >> QS;
        gq      = $signed(GQW'(g_round) - GQW'(1 << (8 + FB)));
        n_e     = EW'(gq) * EW'(LOG_COEF);
    end

    assign fr   = r_e[31+FB -: 16];
    assign oct  = r_e[EW-1 -: 9];
    assign prod = 63'(r_m) * 63'(POW_ROOT[r_idx]);

    always_comb begin
        n_m = r_m;
        if (fr[~r_idx]) begin
            n_m = 32'((prod + 63'(1 << 29)) >> 30);
        end
    end

    always_comb begin
        sh_full = 10'sd14 - 10'(oct);
        sh      = sh_full[4:0];
        m_rnd   = ({1'b0, r_m} + (33'd1 << (sh - 5'd1))) >> sh;
        priority if (oct >= 9'sd7) begin
            n_lin = LIN_MAX;
        end else if (sh_full >= 10'sd32) begin
            n_lin = '0;
        end else if (m_rnd > 33'(LIN_MAX)) begin
            n_lin = LIN_MAX;
        end else begin
            n_lin = m_rnd[21:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: if (i_start) n_state = C_ROOT;
            C_ROOT: if (r_idx == 4'hF) n_state = C_NORM;
            C_NORM: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == C_NORM);
            if (r_state == C_ROOT) begin
                r_idx <= r_idx + 4'd1;
            end else begin
                r_idx <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_e <= n_e;
            r_m <= 32'(1 << 30);
        end
        if (r_state == C_ROOT) begin
            r_m <= n_m;
        end
        if (r_state == C_NORM) begin
            r_lin <= n_lin;
        end
    end

    assign o_done = r_done;
    assign o_lin  = r_lin;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == C_IDLE)
        else $error("converter started while busy");

    a_done_after_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == C_NORM |=> o_done && r_state == C_IDLE)
        else $error("converter missed done");

    a_root_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == C_NORM |-> $past(r_state) == C_ROOT && $past(r_idx) == 4'hF)
        else $error("converter root sweep cut short");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the fade gain block: buffers of samples with
// random frame counts and register settings, random bursts on the request
// side and stalls on the result side. An independent fixed-point gain ramp
// and dB to Q16 converter predicts every scaled sample and the dB gain.
// ============================================================================
module tb;
    import vfg_pkg::*;

    localparam int              FRAC_BITS    = 6;
    localparam int              QUANT_SHIFT  = 16 - FRAC_BITS;
    localparam longint          LOG2_TEN_Q32 = 713378626;   // 2^32 * log2(10) / 20
    localparam longint unsigned LIN_SAT      = 4194303;
    localparam longint          FRAME_CAP    = 4096;
    localparam longint          GAIN_MIN     = -13107200;
    localparam longint          GAIN_MAX     = 1966080;
    localparam int              HOLD_CYC     = 300;
    localparam int              DRAIN_CYC    = 40;
    localparam int              TIMEOUT_CYC  = 400000;

    typedef struct {
        t_sample sample;
        logic    first;
        t_frames frames;
    } t_fade_req;

    typedef struct {
        t_sample  scaled;
        t_gain_db gain;
    } t_scaled_exp;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_wdata;

    vfg_in_if  in_bus ();
    vfg_out_if out_bus ();

    volume_fade_gain #(
        .GAIN_TABLE_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state
    longint          tgt_desired = 0;
    longint          tgt_mute    = -13107200;
    logic            mute_on     = 1'b0;
    longint          fade_rate   = 3277;
    longint          gain_db_now = 0;
    longint unsigned lin_q16_now = 65536;
    longint unsigned root_q30 [16];

    t_fade_req   sample_req_q [$];
    t_scaled_exp scaled_exp_q [$];
    t_fade_req   on_bus_req;
    int          err_cnt      = 0;
    int          results_seen = 0;
    logic        hold_arm     = 1'b0;

    // Request side pacing
    int burst_left = 0;
    int gap_left   = 0;
    // Result side pacing
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   rdy_mode  = 0;
    int   mode_left = 0;

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Gain in 1/65536 dB to linear Q16 factor
    function automatic longint unsigned db_to_q16(longint g);
        longint unsigned gu;
        longint unsigned u;
        longint unsigned fr;
        longint unsigned m;
        longint          gq;
        longint          e;
        longint          n;
        int              sh;
        gu = longint'(g + 16777216);
        gq = longint'((gu + (64'd1 << (QUANT_SHIFT - 1))) >> QUANT_SHIFT)
             - (longint'(1) << (8 + FRAC_BITS));
        e  = gq * LOG2_TEN_Q32;
        u  = longint'(e) + (64'd1 << (39 + FRAC_BITS));
        n  = longint'(u >> (32 + FRAC_BITS)) - 128;
        fr = (u & ((64'd1 << (32 + FRAC_BITS)) - 1)) >> (16 + FRAC_BITS);
        m  = 64'd1 << 30;
        for (int i = 0; i < 16; i++) begin
            if (fr[15 - i]) m = (m * root_q30[i] + (64'd1 << 29)) >> 30;
        end
        if (n >= 7) return LIN_SAT;
        sh = 14 - int'(n);
        if (sh >= 32) return 64'd0;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (m > LIN_SAT) ? LIN_SAT : m;
    endfunction

    // Ramp the gain on a buffer start, then scale the sample
    function automatic t_scaled_exp apply_request(t_fade_req req);
        longint          frames;
        longint          ramp_step;
        longint          target;
        longint          p;
        longint          r;
        longint unsigned mag;
        t_scaled_exp     res;
        if (req.first) begin
            frames = longint'(req.frames);
            if (frames > FRAME_CAP) frames = FRAME_CAP;
            ramp_step = fade_rate * frames;
            target    = mute_on ? tgt_mute : tgt_desired;
            if (gain_db_now < target - ramp_step) begin
                gain_db_now = gain_db_now + ramp_step;
            end else if (gain_db_now > target + ramp_step) begin
                gain_db_now = gain_db_now - ramp_step;
            end else begin
                gain_db_now = target;
            end
            lin_q16_now = db_to_q16(gain_db_now);
        end
        p   = longint'(req.sample) * longint'(lin_q16_now);
        mag = (p < 0) ? longint'(-p) : longint'(p);
        r   = longint'((mag + 32768) >> 16);
        if (p < 0) r = -r;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        res.scaled = r[15:0];
        res.gain   = gain_db_now[24:0];
        return res;
    endfunction

    task automatic flag_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) scaled_exp_q.push_back(apply_request(on_bus_req));
            if (!in_bus.valid || in_bus.ready) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(40, 1);
                    case ($urandom_range(9, 0))
                        0, 1, 2, 3: gap_left = 0;
                        9:          gap_left = $urandom_range(60, 20);
                        default:    gap_left = $urandom_range(6, 1);
                    endcase
                end
                if (gap_left > 0 || sample_req_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    in_bus.valid <= 1'b0;
                end else begin
                    on_bus_req = sample_req_q.pop_front();
                    burst_left--;
                    in_bus.valid           <= 1'b1;
                    in_bus.sample          <= on_bus_req.sample;
                    in_bus.first_in_buffer <= on_bus_req.first;
                    in_bus.buf_frames      <= on_bus_req.frames;
                end
            end
        end
    end

    // Result side stall pattern, with one long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (hold_arm && !hold_done) begin
                hold_left = HOLD_CYC;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rdy_mode  = $urandom_range(3, 0);
                    mode_left = $urandom_range(96, 16);
                end
                mode_left--;
                case (rdy_mode)
                    0:       out_bus.ready <= 1'b1;
                    1:       out_bus.ready <= 1'($urandom_range(1, 0));
                    2:       out_bus.ready <= ($urandom_range(3, 0) == 0);
                    default: out_bus.ready <= ($urandom_range(3, 0) != 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_scaled_exp exp_res;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            results_seen++;
            if (scaled_exp_q.size() == 0) begin
                flag_error($sformatf("unexpected result: sample %0d gain %0d",
                                     out_bus.scaled_sample, out_bus.gain_now));
            end else begin
                exp_res = scaled_exp_q.pop_front();
                if (out_bus.scaled_sample !== exp_res.scaled)
                    flag_error($sformatf("result %0d scaled_sample exp %0d got %0d",
                                         results_seen, exp_res.scaled, out_bus.scaled_sample));
                if (out_bus.gain_now !== exp_res.gain)
                    flag_error($sformatf("result %0d gain_now exp %0d got %0d",
                                         results_seen, exp_res.gain, out_bus.gain_now));
            end
        end
    end

    task automatic push_req(t_sample sample, logic first, t_frames frames);
        t_fade_req req;
        req.sample = sample;
        req.first  = first;
        req.frames = frames;
        sample_req_q.push_back(req);
    endtask

    // Only called while idle, so the predictor can take the value at once
    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_TARGET_GAIN:    tgt_desired = longint'(signed'(data));
            CFG_MUTE_LEVEL:     tgt_mute    = longint'(signed'(data));
            CFG_MUTED:          mute_on     = data[0];
            CFG_FADE_PER_FRAME: fade_rate   = longint'(data[15:0]);
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every request is sent and every result is back
    task automatic drain();
        while (sample_req_q.size() != 0 || in_bus.valid || scaled_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic t_cfg_data pick_gain(longint hi);
        longint v;
        case ($urandom_range(9, 0))
            0:       v = GAIN_MIN;
            1:       v = hi;
            2:       v = 0;
            3:       return t_cfg_data'($urandom);
            default: v = longint'($urandom_range(int'(hi - GAIN_MIN), 0)) + GAIN_MIN;
        endcase
        return t_cfg_data'(v);
    endfunction

    task automatic randomize_regs();
        t_cfg_data d;
        if ($urandom_range(1, 0)) write_reg(CFG_TARGET_GAIN, pick_gain(GAIN_MAX));
        if ($urandom_range(1, 0)) write_reg(CFG_MUTE_LEVEL, pick_gain(0));
        if ($urandom_range(2, 0) == 0) write_reg(CFG_MUTED, t_cfg_data'($urandom));
        if ($urandom_range(1, 0)) begin
            d = t_cfg_data'($urandom);
            case ($urandom_range(9, 0))
                0:       d[15:0] = 16'h0000;
                1:       d[15:0] = 16'hFFFF;
                2, 3:    d[15:0] = 16'($urandom);
                default: d[15:0] = 16'($urandom_range(800, 1));
            endcase
            write_reg(CFG_FADE_PER_FRAME, d);
        end
    endtask

    function automatic t_sample pick_sample();
        case ($urandom_range(9, 0))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return t_sample'(int'($urandom_range(6, 0)) - 3);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Buffers: a start carrying the frame count, then plain samples
    task automatic queue_buffers(int n_items);
        t_frames fc;
        int      len;
        while (n_items > 0) begin
            case ($urandom_range(19, 0))
                0:          fc = 13'd0;
                1:          fc = 13'd4096;
                2:          fc = 13'd4097;
                3:          fc = 13'h1FFF;
                4, 5:       fc = 13'($urandom);
                6, 7, 8, 9: fc = 13'($urandom_range(300, 17));
                default:    fc = 13'($urandom_range(16, 0));
            endcase
            push_req(pick_sample(), 1'b1, fc);
            n_items--;
            len = $urandom_range(20, 0);
            // frame count is noise on plain samples
            for (int k = 0; k < len && n_items > 0; k++) begin
                push_req(pick_sample(), 1'b0, t_frames'($urandom));
                n_items--;
            end
        end
    endtask

    initial begin
        root_q30[0] = floor_sqrt(64'd2 << 60);
        for (int i = 1; i < 16; i++) root_q30[i] = floor_sqrt(root_q30[i - 1] << 30);

        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_TARGET_GAIN;
        i_cfg_wdata            = '0;
        in_bus.valid           = 1'b0;
        in_bus.sample          = '0;
        in_bus.first_in_buffer = 1'b0;
        in_bus.buf_frames      = '0;
        out_bus.ready          = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Unity gain after reset: sample extremes, buffer start with zero frames
        push_req(16'sh7FFF, 1'b0, 13'h1FFF);
        push_req(16'sh8000, 1'b0, 13'h0AAA);
        push_req(16'sh0000, 1'b0, 13'h1555);
        push_req(16'sh0001, 1'b0, 13'd0);
        push_req(-16'sh0001, 1'b0, 13'd7);
        push_req(16'sh5555, 1'b1, 13'd0);
        push_req(16'shAAAA, 1'b0, 13'd0);
        drain();

        // Top of the gain range, oversized frame count: factor saturates
        write_reg(CFG_TARGET_GAIN, 25'h0FFFFFF);
        write_reg(CFG_FADE_PER_FRAME, 25'h1FFFFFF);
        write_reg(CFG_MUTED, 25'h1FFFFFE);
        write_reg(CFG_MUTE_LEVEL, 25'h1000000);
        push_req(16'sh0001, 1'b1, 13'h1FFF);
        push_req(16'sh7FFF, 1'b0, 13'd0);
        push_req(16'sh8000, 1'b0, 13'd0);
        push_req(-16'sh0001, 1'b0, 13'd0);
        drain();

        // Mute to the bottom of the range: factor 0
        write_reg(CFG_MUTED, 25'd1);
        push_req(16'sh7FFF, 1'b1, 13'd4096);
        push_req(16'sh8000, 1'b0, 13'd0);
        drain();

        // Zero fade rate: gain holds off target, then sits on target
        write_reg(CFG_FADE_PER_FRAME, 25'd0);
        write_reg(CFG_MUTED, 25'd0);
        push_req(16'sd1000, 1'b1, 13'd100);
        drain();
        write_reg(CFG_TARGET_GAIN, 25'h1000000);
        push_req(16'sd1000, 1'b1, 13'd0);
        drain();

        // Partial ramps toward 0 dB, frame count just over the cap
        write_reg(CFG_TARGET_GAIN, 25'd0);
        write_reg(CFG_FADE_PER_FRAME, 25'd3277);
        push_req(16'sd20000, 1'b1, 13'd5);
        push_req(16'sd20000, 1'b0, 13'd0);
        push_req(-16'sd20000, 1'b1, 13'd4097);
        push_req(16'sd12345, 1'b0, 13'd0);
        drain();

        // +30 dB: samples right at the saturation edge
        write_reg(CFG_TARGET_GAIN, t_cfg_data'(GAIN_MAX));
        write_reg(CFG_MUTE_LEVEL, t_cfg_data'(GAIN_MIN));
        write_reg(CFG_FADE_PER_FRAME, 25'd65535);
        push_req(16'sd1000, 1'b1, 13'd4096);
        push_req(16'sd1037, 1'b0, 13'd0);
        push_req(-16'sd1036, 1'b0, 13'd0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            randomize_regs();
            if (ph == 4) begin
                queue_buffers(150);
                hold_arm = 1'b1;
            end else begin
                queue_buffers(72);
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(12 * TIMEOUT_CYC);
        $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
rtl/vfg_pkg.sv
rtl/vfg_in_if.sv
rtl/vfg_out_if.sv
rtl/vfg_db2lin.sv
rtl/volume_fade_gain.sv
bench/tb.sv
